[sv/b64d_pkg.sv]
package b64d_pkg;

  // Default width of the per-frame byte counter.
  localparam int COUNT_WIDTH_DEF = 12;

  // Capacity register width and its value after reset.
  localparam int CAP_WIDTH = 13;
  localparam int CAP_RESET = 256;

  // Depth of the job queue between the front and back parts (power of two).
  localparam int JOBQ_DEPTH = 4;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_OK    = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // The padding character.
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // One unit of work for the back part: the decoded group, how many of its
  // bytes go out, and whether a frame status follows them.
  typedef struct packed {
    logic [23:0] group_bits;
    logic [1:0]  num_bytes;
    logic        has_status;
    logic        status_ok;
  } b64d_job_t;

  // Maps a character to {is_alphabet, sextet value}.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    logic       ok;
    v  = 8'd0;
    ok = 1'b1;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      v = 8'd62;
    end else if (c == 8'h2F) begin
      v = 8'd63;
    end else begin
      ok = 1'b0;
    end
    return {ok, v[5:0]};
  endfunction

endpackage

[sv/b64d_front.sv]
module b64d_front #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_accept,
  input  logic [7:0]                     char_code,
  input  logic                           frame_last,
  input  logic                           cfg_write,
  input  logic [b64d_pkg::CAP_WIDTH-1:0] cfg_data,
  output logic                           job_push,
  output b64d_pkg::b64d_job_t            job
);
  import b64d_pkg::*;

  localparam int LW = (COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH;
  localparam int MAXC = (1 << COUNT_WIDTH) - 1;
  localparam int LIM_RESET = (CAP_RESET - 1 > MAXC) ? MAXC : CAP_RESET - 1;

  // Configuration: whether the capacity is nonzero is kept for the status check, and the
  // per-frame byte limit is worked out once at write time.
  logic                   cap_nonzero;
  logic [COUNT_WIDTH-1:0] limit;
  logic [LW-1:0]          wr_cap_m1;
  logic [LW-1:0]          maxc_w;

  assign maxc_w = LW'(MAXC);

  always_comb begin
    if (cfg_data == '0) begin
      wr_cap_m1 = '0;
    end else begin
      wr_cap_m1 = LW'(cfg_data) - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_nonzero <= 1'b1;
      limit       <= COUNT_WIDTH'(LIM_RESET);
    end else if (cfg_write) begin
      cap_nonzero <= (cfg_data != '0);
      limit       <= (wr_cap_m1 > maxc_w) ? COUNT_WIDTH'(MAXC) : wr_cap_m1[COUNT_WIDTH-1:0];
    end
  end

  // Frame state.
  logic [17:0]            acc, acc_next;
  logic [1:0]             pos, pos_next;
  logic                   third_pad, third_pad_next;
  logic [1:0]             len_mod, len_mod_next;
  logic                   stopped, stopped_next;
  logic                   err_seen, err_seen_next;
  logic [COUNT_WIDTH-1:0] emitted, emitted_next;

  logic                   is_pad;
  logic [6:0]             lookup;
  logic                   sym_ok;
  logic [5:0]             sym;
  logic [1:0]             group_count;
  logic [COUNT_WIDTH-1:0] room;
  logic [1:0]             num_bytes;

  assign is_pad = (char_code == PAD_CHAR);
  assign lookup = sextet_of(char_code);
  assign sym_ok = is_pad | lookup[6];
  assign sym    = is_pad ? 6'd0 : lookup[5:0];

  // Bytes this group carries, then trimmed to what is left under the limit.
  assign group_count = third_pad ? 2'd1 : (is_pad ? 2'd2 : 2'd3);

  always_comb begin
    if (emitted >= limit) begin
      room = '0;
    end else begin
      room = limit - emitted;
    end
    if (room < COUNT_WIDTH'(group_count)) begin
      num_bytes = room[1:0];
    end else begin
      num_bytes = group_count;
    end
  end

  // Next-state logic for one accepted character.
  always_comb begin
    acc_next       = acc;
    pos_next       = pos;
    third_pad_next = third_pad;
    len_mod_next   = len_mod;
    stopped_next   = stopped;
    err_seen_next  = err_seen;
    emitted_next   = emitted;
    job_push       = 1'b0;
    job.group_bits = {acc, sym};
    job.num_bytes  = 2'd0;
    job.has_status = 1'b0;
    job.status_ok  = 1'b0;

    if (item_accept) begin
      len_mod_next = len_mod + 2'd1;
      if (!stopped) begin
        if (!sym_ok) begin
          err_seen_next = 1'b1;
          stopped_next  = 1'b1;
        end else if (pos != 2'd3) begin
          if (pos == 2'd2 && is_pad) begin
            third_pad_next = 1'b1;
          end
          acc_next = {acc[11:0], sym};
          pos_next = pos + 2'd1;
        end else begin
          job.num_bytes  = num_bytes;
          emitted_next   = emitted + COUNT_WIDTH'(num_bytes);
          if (third_pad || is_pad) begin
            stopped_next = 1'b1;
          end
          acc_next       = '0;
          pos_next       = 2'd0;
          third_pad_next = 1'b0;
        end
      end

      if (frame_last) begin
        job.has_status = 1'b1;
        job.status_ok  = (len_mod_next == 2'd0) && !err_seen_next && cap_nonzero;
        acc_next       = '0;
        pos_next       = 2'd0;
        third_pad_next = 1'b0;
        len_mod_next   = 2'd0;
        stopped_next   = 1'b0;
        err_seen_next  = 1'b0;
        emitted_next   = '0;
      end

      job_push = (job.num_bytes != 2'd0) || job.has_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      pos       <= 2'd0;
      third_pad <= 1'b0;
      len_mod   <= 2'd0;
      stopped   <= 1'b0;
      err_seen  <= 1'b0;
      emitted   <= '0;
    end else begin
      acc       <= acc_next;
      pos       <= pos_next;
      third_pad <= third_pad_next;
      len_mod   <= len_mod_next;
      stopped   <= stopped_next;
      err_seen  <= err_seen_next;
      emitted   <= emitted_next;
    end
  end

endmodule

[sv/b64d_job_fifo.sv]
module b64d_job_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  b64d_pkg::b64d_job_t wr_job,
  input  logic                rd_en,
  output b64d_pkg::b64d_job_t rd_job,
  output logic                q_full,
  output logic                q_empty
);
  import b64d_pkg::*;

  localparam int PTR_W = $clog2(JOBQ_DEPTH);

  b64d_job_t        slots [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign q_full  = (count == (PTR_W + 1)'(JOBQ_DEPTH));
  assign q_empty = (count == '0);
  assign rd_job  = slots[rd_ptr];

  // Job storage; no reset needed on the payload.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

[sv/b64d_back.sv]
module b64d_back (
  input  logic                clk,
  input  logic                rst,
  input  b64d_pkg::b64d_job_t head_job,
  input  logic                head_valid,
  output logic                head_pop,
  output logic [7:0]          out_byte,
  output logic [1:0]          result_kind,
  output logic                run_last,
  output logic                empty,
  input  logic                pop
);
  import b64d_pkg::*;

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       is_data;
  logic       done;
  logic [7:0] sel_byte;
  logic [1:0] sel_kind;

  assign empty = !out_valid;
  assign load  = head_valid && (!out_valid || pop);

  // Pick the result at the current position within the head job.
  always_comb begin
    is_data = (idx < head_job.num_bytes);
    case (idx)
      2'd0:    sel_byte = head_job.group_bits[23:16];
      2'd1:    sel_byte = head_job.group_bits[15:8];
      2'd2:    sel_byte = head_job.group_bits[7:0];
      default: sel_byte = 8'd0;
    endcase
    if (is_data) begin
      sel_kind = KIND_DATA;
      done     = ((idx + 2'd1) == head_job.num_bytes) && !head_job.has_status;
    end else begin
      sel_byte = 8'd0;
      sel_kind = head_job.status_ok ? KIND_OK : KIND_ERROR;
      done     = 1'b1;
    end
  end

  assign head_pop = load && done;

  // Output register and position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= done ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= sel_byte;
      result_kind <= sel_kind;
      run_last    <= done;
    end
  end

endmodule

[sv/base64_stream_decoder.sv]
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------
// input    | push / full               | char_code, frame_last
// result   | empty / pop               | out_byte, result_kind, run_last
// config   | cfg_valid / cfg_ready     | output_capacity
//
// One character is taken per cycle while the job queue has room; results
// leave at one per cycle from the output register on pop, up to four per
// character. The front decodes a character in the cycle it arrives; its
// first result passes through the job queue and the output register. The
// input stalls only when the four-entry job queue is full; cfg_ready is
// always high. Synchronous reset clears frame state and sets capacity to 256.
module base64_stream_decoder #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [7:0]                     char_code,
  input  logic                           frame_last,
  input  logic                           push,
  output logic                           full,
  output logic [7:0]                     out_byte,
  output logic [1:0]                     result_kind,
  output logic                           run_last,
  output logic                           empty,
  input  logic                           pop,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [b64d_pkg::CAP_WIDTH-1:0] output_capacity
);
  import b64d_pkg::*;

  logic      item_accept;
  logic      job_push;
  logic      job_pop;
  logic      job_full;
  logic      job_empty;
  b64d_job_t new_job;
  b64d_job_t head_job;

  assign cfg_ready   = 1'b1;
  assign full        = job_full;
  assign item_accept = push && !job_full;

  // Front: decodes characters and tracks frame state.
  b64d_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_accept(item_accept),
    .char_code  (char_code),
    .frame_last (frame_last),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data   (output_capacity),
    .job_push   (job_push),
    .job        (new_job)
  );

  // Job queue between the two parts.
  b64d_job_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (new_job),
    .rd_en  (job_pop),
    .rd_job (head_job),
    .q_full (job_full),
    .q_empty(job_empty)
  );

  // Back: serializes each job into result transactions.
  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .head_valid (!job_empty),
    .head_pop   (job_pop),
    .out_byte   (out_byte),
    .result_kind(result_kind),
    .run_last   (run_last),
    .empty      (empty),
    .pop        (pop)
  );

`ifndef SYNTH
  // A status result closes its run and carries a zero byte.
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind != KIND_DATA) |-> (run_last && out_byte == 8'd0))
    else $error("status result without run_last or with nonzero byte");

  // The front never writes into a full job queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full)
    else $error("job queue overflow");

  // A run that is not finished continues in the very next cycle.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !run_last) |=> !empty)
    else $error("gap inside a run of results");
`endif

endmodule
